// File: hdl/ebts_pkg.sv
// ----------------------------------------------------------------------------
// ebts_pkg: shared types and constants of the Erlang B traffic solver
// Fixed-point widths, register map, datapath operations and status bundles.
// ----------------------------------------------------------------------------
package ebts_pkg;

  localparam int MaxChannels = 256;
  localparam int ChanW       = 9;
  localparam int ProbW       = 16;
  localparam int TrafficW    = 32;
  localparam int InvW        = 64;
  localparam int RoundW      = 7;
  localparam int NumW        = ChanW + InvW;
  localparam int DivSteps    = 64;
  localparam int DivCntW     = $clog2(DivSteps);
  localparam int FactorW     = 33;
  localparam int CfgAddrW    = 4;
  localparam int CfgDataW    = 32;

  localparam logic [ProbW-1:0]    StartRatioRst = 16'd52429;
  localparam logic [ProbW-1:0]    ToleranceRst  = 16'd66;
  localparam logic [ProbW-1:0]    StepGainRst   = 16'd32768;
  localparam logic [RoundW-1:0]   MaxRoundsRst  = 7'd10;

  typedef enum logic [1:0] {
    REG_START_RATIO = 2'd0,
    REG_TOLERANCE   = 2'd1,
    REG_STEP_GAIN   = 2'd2,
    REG_MAX_ROUNDS  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROUND_INIT,
    OP_MUL,
    OP_SAT_B,
    OP_DIV_START,
    OP_DIV_END,
    OP_K_INC,
    OP_BDIV_START,
    OP_BDIV_END,
    OP_UPD_FACTOR,
    OP_UPD_TRAFFIC,
    OP_OUT_LOAD
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_STEP,
    ST_BDIV,
    ST_CMP,
    ST_UPD,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic rounds_done;
    logic ovf;
    logic div_busy;
    logic k_last;
    logic converged;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hdl/ebts_div.sv
// ----------------------------------------------------------------------------
// ebts_div: restoring divider, one quotient bit per cycle
// Divides {rem, dividend} by divisor; rem must be below divisor.
// ----------------------------------------------------------------------------
module ebts_div
  import ebts_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [InvW-1:0] rem_i,
  input  logic [InvW-1:0] dividend_i,
  input  logic [InvW-1:0] divisor_i,
  output logic            busy_o,
  output logic [InvW-1:0] quot_o
);

  logic [InvW-1:0]    rem_q, rem_d;
  logic [InvW-1:0]    dvd_q, dvd_d;
  logic [InvW-1:0]    dsr_q, dsr_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [InvW:0]      trial;
  logic [InvW:0]      trial_sub;
  logic               ge;

  assign trial     = {rem_q, dvd_q[InvW-1]};
  assign trial_sub = trial - {1'b0, dsr_q};
  assign ge        = (trial >= {1'b0, dsr_q});

  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = rem_i;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[InvW-1:0] : trial[InvW-1:0];
      dvd_d = {dvd_q[InvW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;

endmodule

// File: hdl/ebts_datapath.sv
// ----------------------------------------------------------------------------
// ebts_datapath: traffic, inverse blocking and update arithmetic
// Holds the working registers, the shared divider and the result register.
// ----------------------------------------------------------------------------
module ebts_datapath
  import ebts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic [ChanW-1:0]    channels_i,
  input  logic [ProbW-1:0]    target_i,
  input  logic [ProbW-1:0]    start_ratio_i,
  input  logic [ProbW-1:0]    tolerance_i,
  input  logic [ProbW-1:0]    step_gain_i,
  input  logic [RoundW-1:0]   max_rounds_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [TrafficW-1:0] out_traffic_o
);

  logic [ChanW-1:0]    n_q, n_d;
  logic [ChanW-1:0]    k_q, k_d;
  logic [ProbW-1:0]    target_q, target_d;
  logic [TrafficW-1:0] a_q, a_d;
  logic [InvW-1:0]     b_q, b_d;
  logic [NumW-1:0]     num_q, num_d;
  logic [ProbW-1:0]    bp_q, bp_d;
  logic [FactorW-1:0]  factor_q, factor_d;
  logic [RoundW-1:0]   round_q, round_d;
  logic [TrafficW-1:0] res_q, res_d;
  logic                res_valid_q, res_valid_d;

  logic [ChanW-1:0]      n_sat;
  logic [24:0]           a_start;
  logic signed [ProbW:0] diff;
  logic [ProbW:0]        diff_abs;
  logic signed [33:0]    corr;
  logic [33:0]           factor_full;
  logic [64:0]           upd_prod;
  logic [32:0]           upd_shift;
  logic                  div_start;
  logic [InvW-1:0]       div_rem;
  logic [InvW-1:0]       div_dvd;
  logic [InvW-1:0]       div_dsr;
  logic                  div_busy;
  logic [InvW-1:0]       div_quot;

  ebts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_i      (div_rem),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign n_sat    = (channels_i > ChanW'(MaxChannels)) ? ChanW'(MaxChannels) : channels_i;
  assign a_start  = 25'(start_ratio_i) * 25'(n_sat);
  assign diff     = $signed({1'b0, target_q}) - $signed({1'b0, bp_q});
  assign diff_abs = diff[ProbW] ? 17'(-diff) : 17'(diff);
  assign corr     = 34'(diff) * $signed({18'd0, step_gain_i});
  assign factor_full = 34'h1_0000_0000 + 34'(corr);
  assign upd_prod  = 65'(a_q) * 65'(factor_q);
  assign upd_shift = upd_prod[64:32];

  always_comb begin
    div_start = 1'b0;
    div_rem   = 64'(num_q[NumW-1:48]);
    div_dvd   = {num_q[47:0], 16'h0000};
    div_dsr   = 64'(a_q);
    if (cmd_i.op == OP_DIV_START) begin
      div_start = 1'b1;
    end else if (cmd_i.op == OP_BDIV_START) begin
      div_start = 1'b1;
      div_rem   = '0;
      div_dvd   = 64'h0001_0000_0000_0000;
      div_dsr   = b_q;
    end
  end

  always_comb begin
    n_d         = n_q;
    k_d         = k_q;
    target_d    = target_q;
    a_d         = a_q;
    b_d         = b_q;
    num_d       = num_q;
    bp_d        = bp_q;
    factor_d    = factor_q;
    round_d     = round_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !out_ready_i;
    case (cmd_i.op)
      OP_LOAD: begin
        n_d      = n_sat;
        target_d = target_i;
        a_d      = 32'(a_start);
        round_d  = '0;
      end
      OP_ROUND_INIT: begin
        b_d = 64'h0000_0001_0000_0000;
        k_d = ChanW'(1);
      end
      OP_MUL: begin
        num_d = NumW'(k_q) * NumW'(b_q);
      end
      OP_SAT_B: begin
        b_d = '1;
      end
      OP_DIV_END: begin
        if (div_quot[63:32] == 32'hFFFF_FFFF) begin
          b_d = '1;
        end else begin
          b_d = {div_quot[63:32] + 32'd1, div_quot[31:0]};
        end
      end
      OP_K_INC: begin
        k_d = k_q + 1'b1;
      end
      OP_BDIV_END: begin
        bp_d = (div_quot[63:16] != 48'd0) ? 16'hFFFF : div_quot[15:0];
      end
      OP_UPD_FACTOR: begin
        factor_d = factor_full[FactorW-1:0];
      end
      OP_UPD_TRAFFIC: begin
        a_d     = upd_shift[32] ? 32'hFFFF_FFFF : upd_shift[31:0];
        round_d = round_q + 1'b1;
      end
      OP_OUT_LOAD: begin
        res_d       = a_q;
        res_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    k_q      <= k_d;
    target_q <= target_d;
    a_q      <= a_d;
    b_q      <= b_d;
    num_q    <= num_d;
    bp_q     <= bp_d;
    factor_q <= factor_d;
    round_q  <= round_d;
    res_q    <= res_d;
  end

  always_comb begin
    sts_o.n_zero      = (n_q == '0);
    sts_o.rounds_done = (round_q == max_rounds_i);
    sts_o.ovf         = ({7'd0, num_q[NumW-1:48]} >= a_q);
    sts_o.div_busy    = div_busy;
    sts_o.k_last      = (k_q == n_q);
    sts_o.converged   = (diff_abs < {1'b0, tolerance_i});
    sts_o.out_free    = !res_valid_q || out_ready_i;
  end

  assign out_valid_o   = res_valid_q;
  assign out_traffic_o = res_q;

endmodule

// File: hdl/ebts_ctrl.sv
// ----------------------------------------------------------------------------
// ebts_ctrl: sequencer of the traffic solver
// Steps the datapath through rounds, recurrence steps and traffic updates.
// ----------------------------------------------------------------------------
module ebts_ctrl
  import ebts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (sts_i.n_zero || sts_i.rounds_done) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.op = OP_ROUND_INIT;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_CHK;
      end
      ST_CHK: begin
        if (sts_i.ovf) begin
          cmd_o.op = OP_SAT_B;
          state_d  = ST_STEP;
        end else begin
          cmd_o.op = OP_DIV_START;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = OP_DIV_END;
          state_d  = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts_i.k_last) begin
          cmd_o.op = OP_BDIV_START;
          state_d  = ST_BDIV;
        end else begin
          cmd_o.op = OP_K_INC;
          state_d  = ST_MUL;
        end
      end
      ST_BDIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = OP_BDIV_END;
          state_d  = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts_i.converged) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.op = OP_UPD_FACTOR;
          state_d  = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.op = OP_UPD_TRAFFIC;
        state_d  = ST_ROUND;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT_LOAD;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/erlang_b_traffic_solver_unit.sv
// ----------------------------------------------------------------------------
// erlang_b_traffic_solver_unit: offered traffic for a target Erlang B blocking
// One transaction is solved at a time, the next accepted in the cycle after the result is
// loaded, and a stalled output adds its stall. Reset restores register defaults and empties
// the result.
// ----------------------------------------------------------------------------
module erlang_b_traffic_solver_unit
  import ebts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [8:0] channels, [24:9] target_blocking, [31:25] zero.
  input  logic [31:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] offered_traffic.
  output logic [31:0]         m_axis_tdata
);

  logic [ProbW-1:0]  start_ratio_q, start_ratio_d;
  logic [ProbW-1:0]  tolerance_q, tolerance_d;
  logic [ProbW-1:0]  step_gain_q, step_gain_d;
  logic [RoundW-1:0] max_rounds_q, max_rounds_d;
  cfg_reg_e          reg_sel;
  logic              cfg_write;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    start_ratio_d = start_ratio_q;
    tolerance_d   = tolerance_q;
    step_gain_d   = step_gain_q;
    max_rounds_d  = max_rounds_q;
    prdata        = '0;
    unique case (reg_sel)
      REG_START_RATIO: begin
        prdata = 32'(start_ratio_q);
        if (cfg_write) start_ratio_d = pwdata[ProbW-1:0];
      end
      REG_TOLERANCE: begin
        prdata = 32'(tolerance_q);
        if (cfg_write) tolerance_d = pwdata[ProbW-1:0];
      end
      REG_STEP_GAIN: begin
        prdata = 32'(step_gain_q);
        if (cfg_write) step_gain_d = pwdata[ProbW-1:0];
      end
      REG_MAX_ROUNDS: begin
        prdata = 32'(max_rounds_q);
        if (cfg_write) max_rounds_d = pwdata[RoundW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ratio_q <= StartRatioRst;
      tolerance_q   <= ToleranceRst;
      step_gain_q   <= StepGainRst;
      max_rounds_q  <= MaxRoundsRst;
    end else begin
      start_ratio_q <= start_ratio_d;
      tolerance_q   <= tolerance_d;
      step_gain_q   <= step_gain_d;
      max_rounds_q  <= max_rounds_d;
    end
  end

  ebts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ebts_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .channels_i    (s_axis_tdata[8:0]),
    .target_i      (s_axis_tdata[24:9]),
    .start_ratio_i (start_ratio_q),
    .tolerance_i   (tolerance_q),
    .step_gain_i   (step_gain_q),
    .max_rounds_i  (max_rounds_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_traffic_o (m_axis_tdata)
  );

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the Erlang B traffic solver unit
// Streams channel count and target blocking queries into the solver under
// several register settings, predicts each offered traffic value in fixed
// point and checks every result transaction in order, with random idling on
// both streams, a long output stall and a quiet final phase.
// ----------------------------------------------------------------------------
module tb;
  import ebts_pkg::*;

  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 8;
  localparam int MaxShown     = 10;
  localparam int HoldCycles   = 3000;
  localparam int SettleCycles = 200;
  localparam int RandomPhases = 5;
  localparam int PhaseQueries = 18;
  localparam int TimeLimit    = 100_000_000;

  typedef struct packed {
    logic [ProbW-1:0] target;
    logic [ChanW-1:0] channels;
  } query_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;

  logic [ProbW-1:0]  cur_start_ratio = StartRatioRst;
  logic [ProbW-1:0]  cur_tolerance   = ToleranceRst;
  logic [ProbW-1:0]  cur_step_gain   = StepGainRst;
  logic [RoundW-1:0] cur_max_rounds  = MaxRoundsRst;

  query_t            query_q[$];
  logic [TrafficW-1:0] traffic_q[$];
  int                mismatches = 0;
  logic              query_taken = 1'b0;
  bit                calm = 1'b0;
  int                hold_req = 0;
  int                holds_seen = 0;
  int                hold_left = 0;
  int                tx_gap = 0;
  int                rx_gap = 0;

  always #HalfPeriod clk_i = ~clk_i;

  erlang_b_traffic_solver_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [InvW-1:0] next_inverse(logic [InvW-1:0] b, int unsigned k,
                                                   logic [TrafficW-1:0] a);
    logic [127:0] num;
    logic [127:0] quo;
    num = (128'(k) * 128'(b)) << 16;
    quo = num / 128'(a);
    if (quo > 128'hFFFF_FFFE_FFFF_FFFF) return '1;
    return quo[63:0] + 64'h1_0000_0000;
  endfunction

  function automatic logic [ProbW-1:0] blocking_at(logic [TrafficW-1:0] a, int unsigned n);
    logic [InvW-1:0] b;
    logic [InvW-1:0] p;
    int unsigned     k;
    b = 64'h1_0000_0000;
    for (k = 1; k <= n; k++)
      b = (a == '0) ? '1 : next_inverse(b, k, a);
    p = (64'd1 << 48) / b;
    return (p > 64'd65535) ? 16'hFFFF : p[15:0];
  endfunction

  function automatic logic [TrafficW-1:0] solve_traffic(query_t q);
    int unsigned      n;
    int unsigned      r;
    logic [63:0]      a;
    logic [63:0]      fac_u;
    logic [63:0]      na;
    logic [ProbW-1:0] bp;
    longint           tgt;
    longint           gain;
    longint           tol;
    longint           d;
    longint           fac;
    n = q.channels;
    if (n > MaxChannels) n = MaxChannels;
    if (n == 0) return '0;
    tgt  = q.target;
    gain = cur_step_gain;
    tol  = cur_tolerance;
    a = 64'(cur_start_ratio) * 64'(n);
    for (r = 0; r < cur_max_rounds; r++) begin
      bp = blocking_at(a[31:0], n);
      d = bp;
      d = tgt - d;
      if ((d < 0 ? -d : d) < tol) break;
      fac = (longint'(1) << 32) + d * gain;
      fac_u = fac;
      na = a * {32'b0, fac_u[63:32]} + ((a * {32'b0, fac_u[31:0]}) >> 32);
      a = (na > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : na;
    end
    return a[31:0];
  endfunction

  function automatic query_t draw_query();
    query_t q;
    if ($urandom_range(0, 6) == 0) q.channels = $urandom_range(11, 40);
    else q.channels = $urandom_range(0, 10);
    if ($urandom_range(0, 1) == 0) q.target = $urandom_range(1, 6554);
    else q.target = $urandom_range(0, 65535);
    return q;
  endfunction

  function automatic void offer(int unsigned n, int unsigned t);
    query_q.push_back('{target: ProbW'(t), channels: ChanW'(n)});
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_START_RATIO: cur_start_ratio = value[ProbW-1:0];
      REG_TOLERANCE:   cur_tolerance = value[ProbW-1:0];
      REG_STEP_GAIN:   cur_step_gain = value[ProbW-1:0];
      REG_MAX_ROUNDS:  cur_max_rounds = value[RoundW-1:0];
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (query_q.size() != 0 || s_axis_tvalid || traffic_q.size() != 0);
  endtask

  task automatic report_mismatch(string what, logic [TrafficW-1:0] want,
                                 logic [TrafficW-1:0] got);
    if (mismatches < MaxShown)
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || query_taken) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && query_q.size() != 0 && $urandom_range(0, 5) == 0) begin
        tx_gap <= $urandom_range(0, 3);
        s_axis_tvalid <= 1'b0;
      end else if (query_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= 32'(query_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req != holds_seen) begin
      holds_seen <= hold_req;
      hold_left <= HoldCycles - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rx_gap <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    logic [TrafficW-1:0] expected_traffic;
    query_taken <= s_axis_tvalid && s_axis_tready;
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (traffic_q.size() == 0) begin
        report_mismatch("unexpected transaction", '0, m_axis_tdata);
      end else begin
        expected_traffic = traffic_q.pop_front();
        if (m_axis_tdata !== expected_traffic)
          report_mismatch("offered_traffic", expected_traffic, m_axis_tdata);
      end
    end
    if (s_axis_tvalid && s_axis_tready)
      traffic_q.push_back(solve_traffic(query_t'(s_axis_tdata[ChanW+ProbW-1:0])));
  end

  initial begin : stimulus
    int phase_no;
    int idx;
    rst_ni = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    offer(0, 0);
    offer(0, 65535);
    offer(1, 0);
    offer(1, 65535);
    offer(1, 6554);
    offer(2, 655);
    offer(4, 1311);
    offer(8, 66);
    offer(10, 3277);
    offer(16, 13107);
    wait_idle();

    write_reg(REG_START_RATIO, 65535);
    write_reg(REG_TOLERANCE, 0);
    write_reg(REG_STEP_GAIN, 65535);
    write_reg(REG_MAX_ROUNDS, 1);
    @(posedge clk_i);
    offer(256, 0);
    offer(511, 65535);
    offer(300, 328);
    wait_idle();

    write_reg(REG_TOLERANCE, 65535);
    write_reg(REG_STEP_GAIN, 0);
    write_reg(REG_MAX_ROUNDS, 0);
    @(posedge clk_i);
    offer(511, 65535);
    offer(5, 100);
    for (idx = 0; idx < 4; idx++)
      offer($urandom_range(0, 511), $urandom_range(0, 65535));
    wait_idle();

    write_reg(REG_START_RATIO, 0);
    @(posedge clk_i);
    offer(256, 1000);
    offer(3, 5);
    wait_idle();

    write_reg(REG_TOLERANCE, 0);
    write_reg(REG_STEP_GAIN, 65535);
    write_reg(REG_MAX_ROUNDS, 127);
    @(posedge clk_i);
    offer(1, 65535);
    offer(3, 0);
    offer(2, 32768);
    wait_idle();

    write_reg(REG_START_RATIO, 52429);
    write_reg(REG_TOLERANCE, 66);
    write_reg(REG_STEP_GAIN, 32768);
    write_reg(REG_MAX_ROUNDS, 2);
    @(posedge clk_i);
    hold_req++;
    for (idx = 0; idx < 8; idx++)
      offer($urandom_range(1, 6), $urandom_range(0, 65535));
    wait_idle();

    for (phase_no = 0; phase_no < RandomPhases; phase_no++) begin
      write_reg(REG_START_RATIO, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(26214, 65535));
      write_reg(REG_TOLERANCE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 700));
      write_reg(REG_STEP_GAIN, $urandom_range(0, 65535));
      write_reg(REG_MAX_ROUNDS, $urandom_range(1, 10));
      @(posedge clk_i);
      if (phase_no == RandomPhases - 1) calm = 1'b1;
      for (idx = 0; idx < PhaseQueries; idx++)
        query_q.push_back(draw_query());
      wait_idle();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && traffic_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TimeLimit);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: erlang_b_traffic_solver_unit.f
hdl/ebts_pkg.sv
hdl/ebts_div.sv
hdl/ebts_datapath.sv
hdl/ebts_ctrl.sv
hdl/erlang_b_traffic_solver_unit.sv
tb/sv/tb.sv
